// ----- hw/rtl/vqm_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, stage counts and fixed-point constants of the mos estimator
package vqm_pkg;

  // port field widths
  localparam int unsigned LOSS_W  = 17;
  localparam int unsigned BURST_W = 24;
  localparam int unsigned MOS_W   = 15;

  // internal datapath widths
  localparam int unsigned PCT_W = 7;
  localparam int unsigned BPL_W = 21;
  localparam int unsigned PL_W  = 23;
  localparam int unsigned NUM_W = 47;
  localparam int unsigned DEN_W = 45;
  localparam int unsigned DVD_W = 63;
  localparam int unsigned Q_W   = 19;
  localparam int unsigned M95_W = 26;
  localparam int unsigned RF_W  = 27;
  localparam int unsigned R_W   = 24;
  // r squared reaches 93.2^2 in q32, which needs 46 bits
  localparam int unsigned RR_W  = 46;
  localparam int unsigned R2_W  = 30;
  localparam int unsigned R3F_W = 54;
  // r cubed reaches 93.2^3 in q16, signed
  localparam int unsigned R3_W  = 37;
  localparam int unsigned C1_W  = 36;
  localparam int unsigned C2_W  = 29;
  localparam int unsigned C3_W  = 22;
  localparam int unsigned P1_W  = 61;
  localparam int unsigned P2_W  = 58;
  localparam int unsigned P3_W  = 59;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned RND_SH = 44;
  localparam int unsigned FRAC_SH = 16;

  // pipeline stage counts
  localparam int unsigned FRONT_ST = 3;
  localparam int unsigned DIV_ST   = Q_W;
  localparam int unsigned POLY_ST  = 6;
  localparam int unsigned NUM_ST   = FRONT_ST + DIV_ST + POLY_ST;

  // input scaling
  localparam logic [LOSS_W-1:0] LOSS_ONE = 17'd65536;
  localparam logic [PCT_W-1:0]  PCT      = 7'd100;
  localparam logic [BPL_W-1:0]  BPL_Q16  = 21'd1131459;

  // r factor
  localparam logic [PCT_W-1:0]         RATE95    = 7'd95;
  localparam logic signed [R_W-1:0]    R0_Q16    = 24'sd6108362;
  localparam logic signed [R_W-1:0]    R_MIN_Q16 = -24'sd4194304;

  // cubic coefficients
  localparam logic signed [ACC_W-1:0] C0_Q56 = 64'sd148730476973985156;
  localparam logic [C1_W-1:0]         C1_Q40 = 36'd34896300042;
  localparam logic [C2_W-1:0]         C2_Q40 = 29'd392130926;
  localparam logic [C3_W-1:0]         C3_Q40 = 22'd3223141;

  // clamp limits and rounding, with c0 folded in
  localparam logic signed [ACC_W-1:0] MOS_ONE_Q56 = 64'sd72057594037927936;
  localparam logic signed [ACC_W-1:0] MOS_MAX_Q56 = 64'sd324259173170675712;
  localparam logic signed [ACC_W-1:0] SUM_LO  = MOS_ONE_Q56 - C0_Q56;
  localparam logic signed [ACC_W-1:0] SUM_HI  = MOS_MAX_Q56 - C0_Q56;
  localparam logic signed [ACC_W-1:0] RND_ADD = C0_Q56 + 64'sd8796093022208;

  localparam logic [MOS_W-1:0] MOS_ONE_Q12 = 15'd4096;
  localparam logic [MOS_W-1:0] MOS_MAX_Q12 = 15'd18432;

endpackage

// ----- hw/rtl/vqm_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for the input and result beats

interface vqm_in_if;
  logic                         valid;
  logic                         ready;
  logic [vqm_pkg::LOSS_W-1:0]   loss_ratio;
  logic [vqm_pkg::BURST_W-1:0]  burst_ratio;

  modport source (output valid, output loss_ratio, output burst_ratio, input ready);
  modport sink   (input valid, input loss_ratio, input burst_ratio, output ready);
endinterface

interface vqm_out_if;
  logic                       valid;
  logic                       ready;
  logic [vqm_pkg::MOS_W-1:0]  mos_score;

  modport source (output valid, output mos_score, input ready);
  modport sink   (input valid, input mos_score, output ready);
endinterface

// ----- hw/rtl/vqm_pipe_ctl.sv -----
`timescale 1ns / 1ps
// per-stage valid bits and bubble-collapsing load enables
module vqm_pipe_ctl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         out_ready_i,
  output logic [vqm_pkg::NUM_ST-1:0]   en_o,
  output logic                         out_valid_o
);

  localparam int unsigned NS = vqm_pkg::NUM_ST;

  logic [NS-1:0] v_q;
  logic [NS-1:0] low_m;

  // a stage may load when the output drains or some stage at or after it is empty
  always_comb begin
    low_m = '0;
    for (int k = 0; k < NS; k++) begin
      low_m   = (NS'(1) << k) - NS'(1);
      en_o[k] = out_ready_i || !(&(v_q | low_m));
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en_o[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en_o[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign out_valid_o = v_q[NS-1];

endmodule

// ----- hw/rtl/vqm_front.sv -----
`timescale 1ns / 1ps
// input scaling: loss saturation, numerator and denominator products
module vqm_front (
  input  logic                           clk_i,
  input  logic [vqm_pkg::FRONT_ST-1:0]   en_i,
  input  logic [vqm_pkg::LOSS_W-1:0]     loss_ratio_i,
  input  logic [vqm_pkg::BURST_W-1:0]    burst_ratio_i,
  output logic [vqm_pkg::DVD_W-1:0]      dvd_o,
  output logic [vqm_pkg::DEN_W-1:0]      den_o,
  output logic                           zero_o
);

  logic [vqm_pkg::LOSS_W-1:0]  lsat;

  logic [vqm_pkg::PL_W-1:0]    pl0_q;
  logic [vqm_pkg::BURST_W-1:0] b0_q;
  logic                        z0_q;

  logic [vqm_pkg::PL_W-1:0]    pl1_q;
  logic [vqm_pkg::NUM_W-1:0]   num1_q;
  logic [vqm_pkg::DEN_W-1:0]   kb1_q;
  logic                        z1_q;

  logic [vqm_pkg::DVD_W-1:0]   dvd2_q;
  logic [vqm_pkg::DEN_W-1:0]   den2_q;
  logic                        z2_q;

  // loss above one saturates to one
  assign lsat = (loss_ratio_i > vqm_pkg::LOSS_ONE) ? vqm_pkg::LOSS_ONE : loss_ratio_i;

  // stage 0: percent loss and zero detect
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pl0_q <= lsat * vqm_pkg::PCT;
      b0_q  <= burst_ratio_i;
      z0_q  <= (loss_ratio_i == '0) || (burst_ratio_i == '0);
    end
  end

  // stage 1: p*b and k*b
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      num1_q <= pl0_q * b0_q;
      kb1_q  <= vqm_pkg::BPL_Q16 * b0_q;
      pl1_q  <= pl0_q;
      z1_q   <= z0_q;
    end
  end

  // stage 2: scaled dividend and p + k*b
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dvd2_q <= {num1_q, 16'b0};
      den2_q <= {pl1_q, 16'b0} + kb1_q;
      z2_q   <= z1_q;
    end
  end

  assign dvd_o  = dvd2_q;
  assign den_o  = den2_q;
  assign zero_o = z2_q;

endmodule

// ----- hw/rtl/vqm_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, msb first
module vqm_div (
  input  logic                          clk_i,
  input  logic [vqm_pkg::DIV_ST-1:0]    en_i,
  input  logic [vqm_pkg::DVD_W-1:0]     dvd_i,
  input  logic [vqm_pkg::DEN_W-1:0]     den_i,
  input  logic                          zero_i,
  output logic [vqm_pkg::Q_W-1:0]       quo_o,
  output logic                          zero_o
);

  localparam int unsigned QW = vqm_pkg::Q_W;
  localparam int unsigned XW = vqm_pkg::DVD_W;
  localparam int unsigned DW = vqm_pkg::DEN_W;

  logic [XW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic          zero_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_st
    localparam int unsigned K = QW - 1 - j;

    logic [XW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] quo_p;
    logic          zero_p;
    logic [XW:0]   dsh;
    logic [XW:0]   diff;

    // previous stage or the divider inputs
    if (j == 0) begin : g_first
      assign rem_p  = dvd_i;
      assign den_p  = den_i;
      assign quo_p  = '0;
      assign zero_p = zero_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign den_p  = den_q[j-1];
      assign quo_p  = quo_q[j-1];
      assign zero_p = zero_q[j-1];
    end

    // trial subtract of the shifted divisor
    assign dsh  = {{(XW + 1 - DW){1'b0}}, den_p} << K;
    assign diff = {1'b0, rem_p} - dsh;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j]  <= diff[XW] ? rem_p : diff[XW-1:0];
        quo_q[j]  <= {quo_p[QW-2:0], ~diff[XW]};
        den_q[j]  <= den_p;
        zero_q[j] <= zero_p;
      end
    end
  end

  assign quo_o  = quo_q[QW-1];
  assign zero_o = zero_q[QW-1];

endmodule

// ----- hw/rtl/vqm_poly.sv -----
`timescale 1ns / 1ps
// r factor, cubic mapping, clamp and rounding to q3.12
module vqm_poly (
  input  logic                          clk_i,
  input  logic [vqm_pkg::POLY_ST-1:0]   en_i,
  input  logic [vqm_pkg::Q_W-1:0]       quo_i,
  input  logic                          zero_i,
  output logic [vqm_pkg::MOS_W-1:0]     mos_o
);

  localparam int unsigned RW = vqm_pkg::R_W;

  logic signed [vqm_pkg::C1_W:0] c1s;
  logic signed [vqm_pkg::C3_W:0] c3s;

  logic [vqm_pkg::M95_W-1:0]     m95;
  logic signed [vqm_pkg::RF_W-1:0] r_full;
  logic signed [2*RW-1:0]        rr_full;
  logic [vqm_pkg::R2_W-1:0]      r2;
  logic signed [vqm_pkg::R3_W-1:0] r3;
  logic signed [vqm_pkg::ACC_W-1:0] rnd;

  logic signed [RW-1:0]               r_q;
  logic signed [RW-1:0]               r1_q;
  logic [vqm_pkg::RR_W-1:0]           rr_q;
  logic signed [vqm_pkg::P1_W-1:0]    p1_q;
  logic [vqm_pkg::P2_W-1:0]           p2_q;
  logic signed [vqm_pkg::R3F_W-1:0]   r3f_q;
  logic signed [vqm_pkg::ACC_W-1:0]   a_q;
  logic signed [vqm_pkg::P3_W-1:0]    p3_q;
  logic signed [vqm_pkg::ACC_W-1:0]   b_q;
  logic [vqm_pkg::MOS_W-1:0]          mos_q;
  logic                               z0_q;
  logic                               z1_q;
  logic                               z2_q;
  logic                               z3_q;
  logic                               z4_q;

  assign c1s = {1'b0, vqm_pkg::C1_Q40};
  assign c3s = {1'b0, vqm_pkg::C3_Q40};

  // stage 0: r = r0 - 95*f, floored at -64
  assign m95    = quo_i * vqm_pkg::RATE95;
  assign r_full = vqm_pkg::R0_Q16 - $signed({1'b0, m95});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q  <= (r_full < vqm_pkg::R_MIN_Q16) ? vqm_pkg::R_MIN_Q16 : r_full[RW-1:0];
      z0_q <= zero_i;
    end
  end

  // stage 1: r squared
  assign rr_full = r_q * r_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rr_q <= rr_full[vqm_pkg::RR_W-1:0];
      r1_q <= r_q;
      z1_q <= z0_q;
    end
  end

  // stage 2: linear and square terms, r2*r for the cube
  assign r2 = rr_q[vqm_pkg::RR_W-1:vqm_pkg::FRAC_SH];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p1_q  <= c1s * r1_q;
      p2_q  <= r2 * vqm_pkg::C2_Q40;
      r3f_q <= $signed({1'b0, r2}) * r1_q;
      z2_q  <= z1_q;
    end
  end

  // stage 3: cube term, partial sum (arithmetic shift floors)
  assign r3 = r3f_q[vqm_pkg::R3_W+vqm_pkg::FRAC_SH-1:vqm_pkg::FRAC_SH];

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      a_q  <= p1_q - $signed({1'b0, p2_q});
      p3_q <= c3s * r3;
      z3_q <= z2_q;
    end
  end

  // stage 4: full sum less c0
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      b_q  <= a_q + p3_q;
      z4_q <= z3_q;
    end
  end

  // stage 5: clamp, round half up, zero-input override
  assign rnd = b_q + vqm_pkg::RND_ADD;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      if (z4_q) begin
        mos_q <= vqm_pkg::MOS_MAX_Q12;
      end else if (b_q < vqm_pkg::SUM_LO) begin
        mos_q <= vqm_pkg::MOS_ONE_Q12;
      end else if (b_q > vqm_pkg::SUM_HI) begin
        mos_q <= vqm_pkg::MOS_MAX_Q12;
      end else begin
        mos_q <= rnd[vqm_pkg::RND_SH+vqm_pkg::MOS_W-1:vqm_pkg::RND_SH];
      end
    end
  end

  assign mos_o = mos_q;

endmodule

// ----- hw/rtl/voice_quality_mos_estimator.sv -----
`timescale 1ns / 1ps
// mos estimator: 28 register stages, one beat per cycle while the output is not stalled
// the 19-stage restoring divider sets the depth
// stalls collapse bubbles stage by stage, so input is taken while results wait
// reset clears the per-stage valid bits only; no clearing pass is needed
module voice_quality_mos_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  vqm_in_if.sink      in_i,
  vqm_out_if.source   out_o
);

  localparam int unsigned F0 = 0;
  localparam int unsigned D0 = vqm_pkg::FRONT_ST;
  localparam int unsigned P0 = vqm_pkg::FRONT_ST + vqm_pkg::DIV_ST;

  logic [vqm_pkg::NUM_ST-1:0] en;
  logic [vqm_pkg::DVD_W-1:0]  dvd;
  logic [vqm_pkg::DEN_W-1:0]  den;
  logic                       zero_f;
  logic [vqm_pkg::Q_W-1:0]    quo;
  logic                       zero_d;
  logic [vqm_pkg::MOS_W-1:0]  mos;
  logic                       out_valid;

  // stage enables and valid bits
  vqm_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .en_o        (en),
    .out_valid_o (out_valid)
  );

  assign in_i.ready = en[0];

  // input scaling
  vqm_front u_front (
    .clk_i         (clk_i),
    .en_i          (en[F0 +: vqm_pkg::FRONT_ST]),
    .loss_ratio_i  (in_i.loss_ratio),
    .burst_ratio_i (in_i.burst_ratio),
    .dvd_o         (dvd),
    .den_o         (den),
    .zero_o        (zero_f)
  );

  // p*b / (p + k*b)
  vqm_div u_div (
    .clk_i  (clk_i),
    .en_i   (en[D0 +: vqm_pkg::DIV_ST]),
    .dvd_i  (dvd),
    .den_i  (den),
    .zero_i (zero_f),
    .quo_o  (quo),
    .zero_o (zero_d)
  );

  // r factor to score
  vqm_poly u_poly (
    .clk_i  (clk_i),
    .en_i   (en[P0 +: vqm_pkg::POLY_ST]),
    .quo_i  (quo),
    .zero_i (zero_d),
    .mos_o  (mos)
  );

  assign out_o.valid     = out_valid;
  assign out_o.mos_score = mos;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// self-checking bench for the mos estimator: directed rows, then random beats under stalls
module testbench;

  typedef logic [vqm_pkg::LOSS_W-1:0]  loss_t;
  typedef logic [vqm_pkg::BURST_W-1:0] burst_t;
  typedef logic [vqm_pkg::MOS_W-1:0]   mos_t;

  // one directed row; the score is typed in only where it is obvious
  typedef struct packed {
    loss_t  loss;
    burst_t burst;
    logic   fixed;
    mos_t   mos;
  } probe_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_PERIODIC, RX_RANDOM} rx_mode_e;

  // scoring constants, kept apart from the design's own
  localparam longint unsigned FULL_LOSS = 64'd65536;
  localparam longint unsigned PLC_K_Q16 = 64'd1131459;
  localparam longint          R_BASE    = 64'sd6108362;
  localparam longint          R_FLOOR   = -64'sd4194304;
  localparam longint          K0_Q56    = 64'sd148730476973985156;
  localparam longint          K1_Q40    = 64'sd34896300042;
  localparam longint          K2_Q40    = 64'sd392130926;
  localparam longint          K3_Q40    = 64'sd3223141;
  localparam longint          ONE_Q56   = 64'sd72057594037927936;
  localparam longint          TOP_Q56   = 64'sd324259173170675712;
  localparam longint          HALF_Q12  = 64'sd8796093022208;
  localparam mos_t            MOS_FLOOR = 15'd4096;
  localparam mos_t            MOS_TOP   = 15'd18432;

  localparam int RAND_ITEMS = 550;
  localparam int DRAIN_CYCLES = 40;
  localparam int N_ROWS = 20;

  logic clk_i;
  logic rst_ni;

  vqm_in_if  in_if ();
  vqm_out_if out_if ();

  voice_quality_mos_estimator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  mos_t mos_expected[$];
  int   mismatch_count = 0;

  probe_row_t directed_rows [N_ROWS] = '{
    '{17'h00000, 24'h000000, 1'b1, MOS_TOP},
    '{17'h00000, 24'hFFFFFF, 1'b1, MOS_TOP},
    '{17'h1FFFF, 24'h000000, 1'b1, MOS_TOP},
    '{17'h10000, 24'h000000, 1'b1, MOS_TOP},
    '{17'h10000, 24'hFFFFFF, 1'b1, MOS_FLOOR},
    '{17'h1FFFF, 24'hFFFFFF, 1'b1, MOS_FLOOR},
    '{17'h00001, 24'h000001, 1'b0, '0},
    '{17'h00001, 24'hFFFFFF, 1'b0, '0},
    '{17'h1FFFF, 24'h000001, 1'b0, '0},
    '{17'h10001, 24'h010000, 1'b0, '0},
    '{17'h10000, 24'h010000, 1'b0, '0},
    '{17'h0028F, 24'h010000, 1'b0, '0},
    '{17'h00CCD, 24'h010000, 1'b0, '0},
    '{17'h0199A, 24'h020000, 1'b0, '0},
    '{17'h08000, 24'h010000, 1'b0, '0},
    '{17'h0AAAA, 24'hAAAAAA, 1'b0, '0},
    '{17'h15555, 24'h555555, 1'b0, '0},
    '{17'h00001, 24'h008000, 1'b0, '0},
    '{17'h04000, 24'h800000, 1'b0, '0},
    '{17'h00400, 24'h000100, 1'b0, '0}
  };

  // r factor from loss and burst, then the cubic, clamped and rounded to q12
  function automatic mos_t mos_from_loss_burst(loss_t loss, burst_t burst);
    longint unsigned lsat, num, den, frac;
    longint r, r2, r3, acc;
    if (loss == '0 || burst == '0) return MOS_TOP;
    lsat = (loss > FULL_LOSS) ? FULL_LOSS : 64'(loss);
    num  = 64'd100 * lsat * 64'(burst);
    den  = 64'd100 * lsat * 64'd65536 + PLC_K_Q16 * 64'(burst);
    frac = (num << 16) / den;
    r = R_BASE - 64'sd95 * longint'(frac);
    if (r < R_FLOOR) r = R_FLOOR;
    r2  = (r * r) >>> 16;
    r3  = (r2 * r) >>> 16;
    acc = K0_Q56 + K1_Q40 * r - K2_Q40 * r2 + K3_Q40 * r3;
    if (acc < ONE_Q56) return MOS_FLOOR;
    if (acc > TOP_Q56) return MOS_TOP;
    return mos_t'((acc + HALF_Q12) >>> 44);
  endfunction

  task automatic report_mismatch(string what, mos_t got, mos_t want);
    $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // one input beat; the score it should give is queued once it is taken
  task automatic drive_beat(loss_t loss, burst_t burst, logic fixed, mos_t mos);
    in_if.valid       <= 1'b1;
    in_if.loss_ratio  <= loss;
    in_if.burst_ratio <= burst;
    do @(posedge clk_i); while (!in_if.ready);
    mos_expected.push_back(fixed ? mos : mos_from_loss_burst(loss, burst));
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (mos_expected.size() != 0) @(posedge clk_i);
  endtask

  // clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver stalls, changing pattern every segment
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_seg_left = 0;
  int unsigned rx_period = 2;
  int unsigned rx_stall = 1;
  int unsigned rx_tick = 0;

  always @(posedge clk_i) begin
    if (rx_seg_left == 0) begin
      rx_seg_left = $urandom_range(50, 300);
      rx_mode     = rx_mode_e'($urandom_range(0, 2));
      rx_period   = $urandom_range(2, 9);
      rx_stall    = $urandom_range(1, rx_period - 1);
    end
    rx_seg_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN: begin
        out_if.ready <= 1'b1;
      end
      RX_PERIODIC: begin
        out_if.ready <= (rx_tick % rx_period) >= rx_stall;
      end
      default: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  // result check against the oldest pending score
  always @(posedge clk_i) begin
    mos_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (mos_expected.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_if.mos_score, '0);
      end else begin
        want = mos_expected.pop_front();
        if (out_if.mos_score !== want)
          report_mismatch("mos_score", out_if.mos_score, want);
      end
    end
  end

  // stimulus
  initial begin
    int     sent;
    int     run_len;
    int     pick;
    loss_t  loss;
    burst_t burst;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.loss_ratio  = '0;
    in_if.burst_ratio = '0;
    out_if.ready      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: zero inputs, extremes, loss saturation, low r clamp
    for (int i = 0; i < N_ROWS; i++) begin
      drive_beat(directed_rows[i].loss, directed_rows[i].burst,
                 directed_rows[i].fixed, directed_rows[i].mos);
      idle_cycles($urandom_range(0, 2));
    end
    wait_drained();

    // random beats in bursts with gaps
    sent = 0;
    while (sent < RAND_ITEMS) begin
      run_len = $urandom_range(1, 24);
      for (int k = 0; k < run_len && sent < RAND_ITEMS; k++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // one side zero
          loss  = $urandom_range(0, 131071);
          burst = $urandom_range(0, 16777215);
          if ($urandom_range(0, 1)) loss = '0;
          else burst = '0;
        end else if (pick == 1) begin
          loss  = $urandom_range(0, 131071);
          burst = $urandom_range(0, 16777215);
        end else if (pick == 2) begin
          // loss at or above one, saturated
          loss  = $urandom_range(65536, 131071);
          burst = $urandom_range(1, 16777215);
        end else if (pick <= 4) begin
          loss  = $urandom_range(1, 700);
          burst = $urandom_range(16384, 196608);
        end else begin
          // realistic loss up to a fifth, burst ratio 0.5 to 5
          loss  = $urandom_range(1, 13107);
          burst = $urandom_range(32768, 327680);
        end
        drive_beat(loss, burst, 1'b0, '0);
        sent++;
        if (sent == RAND_ITEMS / 2) wait_drained();
      end
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
